// ===== hw/rtl/srtf_pkg.sv =====
`default_nettype none

package srtf_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int SLOT_FIELD_W = 4;
   localparam int TIME_IN_W    = 16;
   localparam int TIME_W       = 24;
   localparam int ADDR_W       = 8;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [TIME_IN_W-1:0] rem;
      logic [TIME_IN_W-1:0] arr;
      logic [TIME_IN_W-1:0] bur;
   } slot_word_type;

   typedef struct packed {
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      slot_word_type       wr_data;
   } store_cmd_type;

   typedef struct packed {
      logic                    is_tick;
      logic                    idle;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic                    finished;
      logic [TIME_W-1:0]       finish_time;
      logic [TIME_W-1:0]       turnaround;
      logic [TIME_W-1:0]       waiting;
      logic                    all_done;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srtf_if.sv =====
`default_nettype none

interface srtf_req_if;
   import srtf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    op;
   logic [SLOT_FIELD_W-1:0] slot;
   logic [TIME_IN_W-1:0]    arrival;
   logic [TIME_IN_W-1:0]    burst;

   modport source (output valid, output op, output slot, output arrival, output burst,
                   input ready);
   modport sink   (input valid, input op, input slot, input arrival, input burst,
                   output ready);
endinterface

interface srtf_rsp_if;
   import srtf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    is_tick;
   logic                    idle;
   logic [SLOT_FIELD_W-1:0] chosen_slot;
   logic                    finished;
   logic [TIME_W-1:0]       finish_time;
   logic [TIME_W-1:0]       turnaround;
   logic [TIME_W-1:0]       waiting;
   logic                    all_done;

   modport source (output valid, output is_tick, output idle, output chosen_slot,
                   output finished, output finish_time, output turnaround,
                   output waiting, output all_done, input ready);
   modport sink   (input valid, input is_tick, input idle, input chosen_slot,
                   input finished, input finish_time, input turnaround,
                   input waiting, input all_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srtf_slot_store.sv =====
`default_nettype none

module srtf_slot_store #(
   parameter int SLOTS = srtf_pkg::SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  srtf_pkg::store_cmd_type    cmd,
   output srtf_pkg::slot_word_type    rd_word
);
   import srtf_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   slot_word_type           mem [SLOTS];
   logic [SLOTS-1:0]        vld_ff;
   slot_word_type           rd_data_ff;
   logic                    rd_vld_ff;
   logic [SLOT_W-1:0]       wa;
   logic [SLOT_W-1:0]       ra;

   assign wa = cmd.wr_addr[SLOT_W-1:0];
   assign ra = cmd.rd_addr[SLOT_W-1:0];

   // written-since-reset flags; an unwritten entry reads as zero remaining time
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.wr_en) begin
         vld_ff[wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wa] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ra];
         rd_vld_ff  <= vld_ff[ra];
      end
   end

   always_comb begin
      rd_word = rd_data_ff;
      if (!rd_vld_ff) begin
         rd_word.rem = '0;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srtf_tick_scheduler_unit.sv =====
`default_nettype none

// Channel | Dir | Fields                                   | Item
// req_if  | in  | op, slot, arrival, burst                 | load or tick command
// rsp_if  | out | is_tick, idle, chosen_slot, finished,    | one result per command
//         |     | finish_time, turnaround, waiting,        |
//         |     | all_done                                 |
//
// A load item goes from acceptance to the output register via slot read, write back
// and output (an out-of-range slot skips the first two); a tick item via a scan that
// reads one slot a cycle off the store's single read port, write back, result, output.
// One item is in flight at a time; req_if.ready is high only in the idle state.
// Synchronous reset clears time, the live-slot count and all slot valid flags.
// A stalled result holds in the output register; a new item may be accepted meanwhile.

module srtf_tick_scheduler_unit #(
   parameter int SLOTS = srtf_pkg::SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srtf_req_if.sink   req_if,
   srtf_rsp_if.source rsp_if
);
   import srtf_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [8:0]        SLOTS_9   = 9'(SLOTS);
   localparam logic [TIME_W-1:0] NOW_MAX   = '1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_LD_RD    = 7'b0000010,
      ST_LD_WR    = 7'b0000100,
      ST_SCAN     = 7'b0001000,
      ST_TICK_WB  = 7'b0010000,
      ST_TICK_FIN = 7'b0100000,
      ST_OUT      = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       ld_addr_ff, ld_addr_in;
   logic [TIME_IN_W-1:0]    ld_arr_ff, ld_arr_in;
   logic [TIME_IN_W-1:0]    ld_bur_ff, ld_bur_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [SLOT_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       best_idx_ff, best_idx_in;
   logic [TIME_IN_W-1:0]    best_rem_ff, best_rem_in;
   logic [TIME_IN_W-1:0]    best_arr_ff, best_arr_in;
   logic [TIME_IN_W-1:0]    best_bur_ff, best_bur_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [TIME_W-1:0]       tat_ff, tat_in;
   logic [CNT_W-1:0]        live_ff, live_in;
   rsp_payload_type         res_ff, res_in;
   rsp_payload_type         rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   store_cmd_type           cmd;
   slot_word_type           rd_word;
   logic [TIME_W-1:0]       now_inc;
   logic                    cand;
   logic                    old_live;
   logic                    new_live;
   logic [TIME_W-1:0]       bur_wide;

   srtf_slot_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_word (rd_word)
   );

   // saturating time step
   assign now_inc  = (now_ff != NOW_MAX) ? now_ff + TIME_W'(1) : now_ff;
   assign bur_wide = TIME_W'(best_bur_ff);

   // slot returning from the store competes for the run this tick
   assign cand = pend_ff && (rd_word.rem != '0) && (TIME_W'(rd_word.arr) <= now_ff) &&
                 (!found_ff || (rd_word.rem < best_rem_ff));

   assign old_live = (rd_word.rem != '0);
   assign new_live = (ld_bur_ff != '0);

   always_comb begin
      state_in     = state_ff;
      ld_addr_in   = ld_addr_ff;
      ld_arr_in    = ld_arr_ff;
      ld_bur_in    = ld_bur_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      now_in       = now_ff;
      tat_in       = tat_ff;
      live_in      = live_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               ld_addr_in = ADDR_W'(req_if.slot);
               ld_arr_in  = req_if.arrival;
               ld_bur_in  = req_if.burst;
               if (req_if.op == OP_TICK) begin
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (9'(req_if.slot) < SLOTS_9) begin
                  state_in = ST_LD_RD;
               end else begin
                  // out-of-range slot: drop the load, still answer it
                  res_in   = '0;
                  state_in = ST_OUT;
               end
            end
         end

         ST_LD_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ld_addr_ff;
            state_in    = ST_LD_WR;
         end

         ST_LD_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr     = ld_addr_ff;
            cmd.wr_data.rem = ld_bur_ff;
            cmd.wr_data.arr = ld_arr_ff;
            cmd.wr_data.bur = ld_bur_ff;
            if (old_live && !new_live) begin
               live_in = live_ff - CNT_W'(1);
            end else if (!old_live && new_live) begin
               live_in = live_ff + CNT_W'(1);
            end
            res_in   = '0;
            state_in = ST_OUT;
         end

         ST_SCAN: begin
            // issue one slot read a cycle, compare the slot read the cycle before
            if (cnt_ff < SLOTS_CNT) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = ADDR_W'(cnt_ff);
               cnt_in      = cnt_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[SLOT_W-1:0];
            end else begin
               pend_in  = 1'b0;
               state_in = ST_TICK_WB;
            end
            if (cand) begin
               found_in    = 1'b1;
               best_idx_in = pend_idx_ff;
               best_rem_in = rd_word.rem;
               best_arr_in = rd_word.arr;
               best_bur_in = rd_word.bur;
            end
         end

         ST_TICK_WB: begin
            now_in = now_inc;
            tat_in = now_inc - TIME_W'(best_arr_ff);
            if (found_ff) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr     = ADDR_W'(best_idx_ff);
               cmd.wr_data.rem = best_rem_ff - TIME_IN_W'(1);
               cmd.wr_data.arr = best_arr_ff;
               cmd.wr_data.bur = best_bur_ff;
               if (best_rem_ff == TIME_IN_W'(1)) begin
                  live_in = live_ff - CNT_W'(1);
               end
            end
            state_in = ST_TICK_FIN;
         end

         ST_TICK_FIN: begin
            res_in         = '0;
            res_in.is_tick = 1'b1;
            res_in.idle    = !found_ff;
            if (found_ff) begin
               res_in.chosen_slot = SLOT_FIELD_W'(best_idx_ff);
               if (best_rem_ff == TIME_IN_W'(1)) begin
                  res_in.finished    = 1'b1;
                  res_in.finish_time = now_ff;
                  res_in.turnaround  = tat_ff;
                  // clamp: only reachable once time has saturated
                  res_in.waiting = (tat_ff >= bur_wide) ? tat_ff - bur_wide : '0;
               end
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_in          = res_ff;
               rsp_in.all_done = (live_ff == '0);
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         now_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         now_ff       <= now_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_addr_ff  <= ld_addr_in;
      ld_arr_ff   <= ld_arr_in;
      ld_bur_ff   <= ld_bur_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      tat_ff      <= tat_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.is_tick     = rsp_ff.is_tick;
   assign rsp_if.idle        = rsp_ff.idle;
   assign rsp_if.chosen_slot = rsp_ff.chosen_slot;
   assign rsp_if.finished    = rsp_ff.finished;
   assign rsp_if.finish_time = rsp_ff.finish_time;
   assign rsp_if.turnaround  = rsp_ff.turnaround;
   assign rsp_if.waiting     = rsp_ff.waiting;
   assign rsp_if.all_done    = rsp_ff.all_done;

endmodule

`default_nettype wire

// ===== hw/rtl/srtf_sched_checker.sv =====
`default_nettype none

module srtf_sched_props (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            is_tick,
   input wire logic                            idle,
   input wire logic [srtf_pkg::SLOT_FIELD_W-1:0] chosen_slot,
   input wire logic                            finished,
   input wire logic [srtf_pkg::TIME_W-1:0]     finish_time,
   input wire logic [srtf_pkg::TIME_W-1:0]     turnaround,
   input wire logic [srtf_pkg::TIME_W-1:0]     waiting
);
   import srtf_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // nothing offered straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a load answer carries no scheduling information
   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_tick |-> !idle && !finished && (chosen_slot == '0) &&
                                (finish_time == '0))
      else $error("load result carries tick fields");

   // an idle tick ran nothing
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && idle |-> is_tick && !finished && (chosen_slot == '0) &&
                            (turnaround == '0))
      else $error("idle tick reports a slot");

   // times of a finished process are ordered
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished |-> is_tick && !idle && (turnaround <= finish_time) &&
                                (waiting < turnaround))
      else $error("finish times out of order");

endmodule

bind srtf_tick_scheduler_unit srtf_sched_props u_sched_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .is_tick     (rsp_if.is_tick),
   .idle        (rsp_if.idle),
   .chosen_slot (rsp_if.chosen_slot),
   .finished    (rsp_if.finished),
   .finish_time (rsp_if.finish_time),
   .turnaround  (rsp_if.turnaround),
   .waiting     (rsp_if.waiting)
);

`default_nettype wire
